// ===== rtl/dbmd_pkg.sv =====
// Shared types, constants and DES bit-level functions for the block-mode decryptor.
package dbmd_pkg;

    localparam int BLK_W   = 64;
    localparam int KEY_W   = 64;
    localparam int MODE_W  = 3;
    localparam int CFG_IDX_W = 2;
    localparam int ROUNDS  = 16;
    localparam int Q_DEPTH_DEF = 2;

    localparam logic [MODE_W-1:0] MODE_ECB = 3'd0;
    localparam logic [MODE_W-1:0] MODE_CBC = 3'd1;
    localparam logic [MODE_W-1:0] MODE_CFB = 3'd2;
    localparam logic [MODE_W-1:0] MODE_OFB = 3'd3;
    localparam logic [MODE_W-1:0] MODE_CTR = 3'd4;

    localparam logic [CFG_IDX_W-1:0] CFG_MODE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_IV   = 2'd2;

    // Classified work item handed from front to back
    typedef struct packed {
        logic [BLK_W-1:0] din;      // DES input block
        logic [BLK_W-1:0] xor_val;  // XORed into the DES output
        logic             decrypt;
        logic             ofb;      // keystream goes back to the front
        logic             last;
    } t_job;

    // Keystream returned to the front for OFB chaining
    typedef struct packed {
        logic             valid;
        logic [BLK_W-1:0] ks;
    } t_fb_ret;

    typedef logic [47:0] t_rkeys [ROUNDS];

    localparam logic [6:0] TAB_IP [64] = '{
        58,50,42,34,26,18,10,2,60,52,44,36,28,20,12,4,
        62,54,46,38,30,22,14,6,64,56,48,40,32,24,16,8,
        57,49,41,33,25,17,9,1,59,51,43,35,27,19,11,3,
        61,53,45,37,29,21,13,5,63,55,47,39,31,23,15,7};
    localparam logic [6:0] TAB_FP [64] = '{
        40,8,48,16,56,24,64,32,39,7,47,15,55,23,63,31,
        38,6,46,14,54,22,62,30,37,5,45,13,53,21,61,29,
        36,4,44,12,52,20,60,28,35,3,43,11,51,19,59,27,
        34,2,42,10,50,18,58,26,33,1,41,9,49,17,57,25};
    localparam logic [5:0] TAB_E [48] = '{
        32,1,2,3,4,5,4,5,6,7,8,9,8,9,10,11,12,13,12,13,14,15,16,17,
        16,17,18,19,20,21,20,21,22,23,24,25,24,25,26,27,28,29,28,29,30,31,32,1};
    localparam logic [5:0] TAB_P [32] = '{
        16,7,20,21,29,12,28,17,1,15,23,26,5,18,31,10,
        2,8,24,14,32,27,3,9,19,13,30,6,22,11,4,25};
    localparam logic [6:0] TAB_PC1 [56] = '{
        57,49,41,33,25,17,9,1,58,50,42,34,26,18,10,2,59,51,43,35,27,19,11,3,
        60,52,44,36,63,55,47,39,31,23,15,7,62,54,46,38,30,22,14,6,61,53,45,37,
        29,21,13,5,28,20,12,4};
    localparam logic [5:0] TAB_PC2 [48] = '{
        14,17,11,24,1,5,3,28,15,6,21,10,23,19,12,4,26,8,16,7,27,20,13,2,
        41,52,31,37,47,55,30,40,51,45,33,48,44,49,39,56,34,53,46,42,50,36,29,32};
    localparam logic [1:0] TAB_ROT [16] = '{1,1,2,2,2,2,2,2,1,2,2,2,2,2,2,1};
    localparam logic [3:0] TAB_S [8][64] = '{
        '{14,4,13,1,2,15,11,8,3,10,6,12,5,9,0,7,0,15,7,4,14,2,13,1,10,6,12,11,9,5,3,8,
          4,1,14,8,13,6,2,11,15,12,9,7,3,10,5,0,15,12,8,2,4,9,1,7,5,11,3,14,10,0,6,13},
        '{15,1,8,14,6,11,3,4,9,7,2,13,12,0,5,10,3,13,4,7,15,2,8,14,12,0,1,10,6,9,11,5,
          0,14,7,11,10,4,13,1,5,8,12,6,9,3,2,15,13,8,10,1,3,15,4,2,11,6,7,12,0,5,14,9},
        '{10,0,9,14,6,3,15,5,1,13,12,7,11,4,2,8,13,7,0,9,3,4,6,10,2,8,5,14,12,11,15,1,
          13,6,4,9,8,15,3,0,11,1,2,12,5,10,14,7,1,10,13,0,6,9,8,7,4,15,14,3,11,5,2,12},
        '{7,13,14,3,0,6,9,10,1,2,8,5,11,12,4,15,13,8,11,5,6,15,0,3,4,7,2,12,1,10,14,9,
          10,6,9,0,12,11,7,13,15,1,3,14,5,2,8,4,3,15,0,6,10,1,13,8,9,4,5,11,12,7,2,14},
        '{2,12,4,1,7,10,11,6,8,5,3,15,13,0,14,9,14,11,2,12,4,7,13,1,5,0,15,10,3,9,8,6,
          4,2,1,11,10,13,7,8,15,9,12,5,6,3,0,14,11,8,12,7,1,14,2,13,6,15,0,9,10,4,5,3},
        '{12,1,10,15,9,2,6,8,0,13,3,4,14,7,5,11,10,15,4,2,7,12,9,5,6,1,13,14,0,11,3,8,
          9,14,15,5,2,8,12,3,7,0,4,10,1,13,11,6,4,3,2,12,9,5,15,10,11,14,1,7,6,0,8,13},
        '{4,11,2,14,15,0,8,13,3,12,9,7,5,10,6,1,13,0,11,7,4,9,1,10,14,3,5,12,2,15,8,6,
          1,4,11,13,12,3,7,14,10,15,6,8,0,5,9,2,6,11,13,8,1,4,10,7,9,5,0,15,14,2,3,12},
        '{13,2,8,4,6,15,11,1,10,9,3,14,5,0,12,7,1,15,13,8,10,3,7,4,12,5,6,11,0,14,9,2,
          7,11,4,1,9,12,14,2,0,6,10,13,15,3,5,8,2,1,14,7,4,10,8,13,15,12,9,0,3,5,6,11}};

    // Table entries count from 1 at the MSB
    function automatic logic [63:0] perm_ip(input logic [63:0] x);
        logic [63:0] r;
        for (int i = 0; i < 64; i++) r[63-i] = x[64 - int'(TAB_IP[i])];
        return r;
    endfunction

    function automatic logic [63:0] perm_fp(input logic [63:0] x);
        logic [63:0] r;
        for (int i = 0; i < 64; i++) r[63-i] = x[64 - int'(TAB_FP[i])];
        return r;
    endfunction

    function automatic t_rkeys round_keys(input logic [63:0] key);
        t_rkeys rk;
        logic [55:0] cd;
        logic [27:0] c;
        logic [27:0] d;
        logic [55:0] cat;
        for (int i = 0; i < 56; i++) cd[55-i] = key[64 - int'(TAB_PC1[i])];
        c = cd[55:28];
        d = cd[27:0];
        for (int k = 0; k < ROUNDS; k++) begin
            if (TAB_ROT[k] == 2'd1) begin
                c = {c[26:0], c[27]};
                d = {d[26:0], d[27]};
            end else begin
                c = {c[25:0], c[27:26]};
                d = {d[25:0], d[27:26]};
            end
            cat = {c, d};
            for (int i = 0; i < 48; i++) rk[k][47-i] = cat[56 - int'(TAB_PC2[i])];
        end
        return rk;
    endfunction

    function automatic logic [31:0] feistel(input logic [31:0] r, input logic [47:0] k);
        logic [47:0] x;
        logic [31:0] s;
        logic [31:0] p;
        logic [5:0]  six;
        for (int i = 0; i < 48; i++) x[47-i] = r[32 - int'(TAB_E[i])];
        x = x ^ k;
        for (int j = 0; j < 8; j++) begin
            six = x[47-6*j -: 6];
            s[31-4*j -: 4] = TAB_S[j][{six[5], six[0], six[4:1]}];
        end
        for (int i = 0; i < 32; i++) p[31-i] = s[32 - int'(TAB_P[i])];
        return p;
    endfunction

endpackage

// ===== rtl/dbmd_in_if.sv =====
// Ciphertext input channel.
interface dbmd_in_if;
    logic        valid;
    logic        ready;
    logic [63:0] cipher_block;
    logic        last_block;
    modport source (output valid, output cipher_block, output last_block, input ready);
    modport sink   (input valid, input cipher_block, input last_block, output ready);
endinterface

// ===== rtl/dbmd_out_if.sv =====
// Plaintext output channel.
interface dbmd_out_if;
    logic        valid;
    logic        ready;
    logic [63:0] plain_block;
    logic        last_out;
    modport source (output valid, output plain_block, output last_out, input ready);
    modport sink   (input valid, input plain_block, input last_out, output ready);
endinterface

// ===== rtl/dbmd_front.sv =====
// Front end: config registers, chaining state and per-beat classification.
module dbmd_front (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [dbmd_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [63:0]                  i_cfg_data,
    input  logic                         i_valid,
    output logic                         o_ready,
    input  logic [63:0]                  i_cipher_block,
    input  logic                         i_last_block,
    input  logic                         i_q_ready,
    output logic                         o_q_valid,
    output dbmd_pkg::t_job               o_q_job,
    input  dbmd_pkg::t_fb_ret            i_ret,
    output logic [63:0]                  o_key
);
    import dbmd_pkg::*;

    logic [MODE_W-1:0] r_mode;
    logic [63:0]       r_key;
    logic [63:0]       r_iv;
    logic [63:0]       r_chain, n_chain;
    logic              r_start, n_start;
    logic              r_pend, n_pend;
    logic              fire;
    logic [63:0]       fb;

    assign o_ready   = i_q_ready && !r_pend;
    assign fire      = i_valid && o_ready;
    assign o_q_valid = i_valid && !r_pend;
    assign o_key     = r_key;
    assign fb        = r_start ? r_iv : r_chain;

    always_comb begin
        o_q_job.last    = i_last_block;
        o_q_job.ofb     = 1'b0;
        o_q_job.decrypt = 1'b0;
        o_q_job.din     = fb;
        o_q_job.xor_val = i_cipher_block;
        n_chain = r_chain;
        case (r_mode)
            MODE_CBC: begin
                o_q_job.decrypt = 1'b1;
                o_q_job.din     = i_cipher_block;
                o_q_job.xor_val = fb;
                n_chain         = i_cipher_block;
            end
            MODE_CFB: n_chain = i_cipher_block;
            MODE_OFB: o_q_job.ofb = 1'b1;
            MODE_CTR: n_chain = fb + 64'd1;
            default: begin
                o_q_job.decrypt = 1'b1;
                o_q_job.din     = i_cipher_block;
                o_q_job.xor_val = '0;
            end
        endcase
        if (!fire) n_chain = r_chain;
        if (i_ret.valid) n_chain = i_ret.ks;
    end

    always_comb begin
        n_start = r_start;
        n_pend  = r_pend;
        if (fire) begin
            if (i_last_block) n_start = 1'b1;
            else if (r_mode >= MODE_CBC && r_mode <= MODE_CTR) n_start = 1'b0;
            if (r_mode == MODE_OFB) n_pend = 1'b1;
        end
        if (i_ret.valid) n_pend = 1'b0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= MODE_ECB;
            r_key   <= '0;
            r_iv    <= '0;
            r_chain <= '0;
            r_start <= 1'b1;
            r_pend  <= 1'b0;
        end else begin
            r_chain <= n_chain;
            r_start <= n_start;
            r_pend  <= n_pend;
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_MODE: r_mode <= i_cfg_data[MODE_W-1:0];
                    CFG_KEY:  r_key  <= i_cfg_data;
                    CFG_IV:   r_iv   <= i_cfg_data;
                    default: ;
                endcase
            end
        end
    end
endmodule

// ===== rtl/dbmd_fifo.sv =====
// Short job queue between front end and round pipeline.
module dbmd_fifo #(
    parameter int DEPTH = dbmd_pkg::Q_DEPTH_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_wr_valid,
    output logic           o_wr_ready,
    input  dbmd_pkg::t_job i_wr_job,
    output logic           o_rd_valid,
    input  logic           i_rd_ready,
    output dbmd_pkg::t_job o_rd_job
);
    import dbmd_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_job           r_mem [DEPTH];
    logic [AW-1:0]  r_wp, r_rp;
    logic [CW-1:0]  r_cnt;
    logic           wr, rd;

    assign o_wr_ready = r_cnt != CW'(DEPTH);
    assign o_rd_valid = r_cnt != '0;
    assign wr = i_wr_valid && o_wr_ready;
    assign rd = o_rd_valid && i_rd_ready;
    assign o_rd_job = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (wr) r_mem[r_wp] <= i_wr_job;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (wr) r_wp <= (r_wp == AW'(DEPTH-1)) ? '0 : r_wp + AW'(1);
            if (rd) r_rp <= (r_rp == AW'(DEPTH-1)) ? '0 : r_rp + AW'(1);
            r_cnt <= r_cnt + CW'(wr) - CW'(rd);
        end
    end
endmodule

// ===== rtl/dbmd_core.sv =====
// Back end: 16-stage DES round pipeline, output XOR and output register.
module dbmd_core (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic [63:0]       i_key,
    input  logic              i_q_valid,
    output logic              o_q_ready,
    input  dbmd_pkg::t_job    i_q_job,
    output dbmd_pkg::t_fb_ret o_ret,
    dbmd_out_if.source        o_blk
);
    import dbmd_pkg::*;

    localparam int NS = ROUNDS + 1;

    t_rkeys       rk;
    logic         en;
    logic         r_v    [NS];
    logic [31:0]  r_l    [NS];
    logic [31:0]  r_r    [NS];
    logic         r_dec  [NS];
    logic         r_ofb  [NS];
    logic         r_last [NS];
    logic [63:0]  r_xv   [NS];
    logic         r_ov;
    logic [63:0]  r_op;
    logic         r_ol;
    logic [63:0]  ip_in;
    logic [63:0]  ks;

    assign rk        = round_keys(i_key);
    assign en        = !r_ov || o_blk.ready;
    assign o_q_ready = en;
    assign ip_in     = perm_ip(i_q_job.din);
    assign ks        = perm_fp({r_r[ROUNDS], r_l[ROUNDS]});
    assign o_ret.valid = en && r_v[ROUNDS] && r_ofb[ROUNDS];
    assign o_ret.ks    = ks;

    assign o_blk.valid       = r_ov;
    assign o_blk.plain_block = r_op;
    assign o_blk.last_out    = r_ol;

    // payload
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_l[0]    <= ip_in[63:32];
            r_r[0]    <= ip_in[31:0];
            r_dec[0]  <= i_q_job.decrypt;
            r_ofb[0]  <= i_q_job.ofb;
            r_last[0] <= i_q_job.last;
            r_xv[0]   <= i_q_job.xor_val;
            for (int k = 0; k < ROUNDS; k++) begin
                r_l[k+1]    <= r_r[k];
                r_r[k+1]    <= r_l[k] ^ feistel(r_r[k],
                                   r_dec[k] ? rk[ROUNDS-1-k] : rk[k]);
                r_dec[k+1]  <= r_dec[k];
                r_ofb[k+1]  <= r_ofb[k];
                r_last[k+1] <= r_last[k];
                r_xv[k+1]   <= r_xv[k];
            end
            r_op <= ks ^ r_xv[ROUNDS];
            r_ol <= r_last[ROUNDS];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NS; k++) r_v[k] <= 1'b0;
            r_ov <= 1'b0;
        end else if (en) begin
            r_v[0] <= i_q_valid;
            for (int k = 0; k < ROUNDS; k++) r_v[k+1] <= r_v[k];
            r_ov <= r_v[ROUNDS];
        end
    end
endmodule

// ===== rtl/des_block_mode_decrypt.sv =====
// Top level: DES decryption in ECB, CBC, CFB, OFB and CTR modes.
//
//   channel   dir  payload                       handshake
//   i_blk     in   cipher_block[64], last_block  valid/ready
//   o_blk     out  plain_block[64], last_out     valid/ready
//   i_cfg_*   in   idx 0 mode, 1 key, 2 iv       write enable only
//
// From the accepting edge a block passes the queue, IP stage, 16 round stages and
// output register to output valid. ECB, CBC, CFB and CTR take one beat per cycle
// unless stalled. An OFB beat holds the input until its keystream leaves the last
// round stage. The round pipeline stalls as a whole while the output register is
// full and not taken. Reset is synchronous, active low.
module des_block_mode_decrypt #(
    parameter int Q_DEPTH = dbmd_pkg::Q_DEPTH_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [dbmd_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [63:0]                    i_cfg_data,
    dbmd_in_if.sink                        i_blk,
    dbmd_out_if.source                     o_blk
);
    import dbmd_pkg::*;

    logic    fq_valid, fq_ready, qc_valid, qc_ready;
    t_job    fq_job, qc_job;
    t_fb_ret ret;
    logic [63:0] key;

    dbmd_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data),
        .i_valid        (i_blk.valid),
        .o_ready        (i_blk.ready),
        .i_cipher_block (i_blk.cipher_block),
        .i_last_block   (i_blk.last_block),
        .i_q_ready      (fq_ready),
        .o_q_valid      (fq_valid),
        .o_q_job        (fq_job),
        .i_ret          (ret),
        .o_key          (key)
    );

    dbmd_fifo #(.DEPTH(Q_DEPTH)) u_fifo (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_valid (fq_valid),
        .o_wr_ready (fq_ready),
        .i_wr_job   (fq_job),
        .o_rd_valid (qc_valid),
        .i_rd_ready (qc_ready),
        .o_rd_job   (qc_job)
    );

    dbmd_core u_core (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_key     (key),
        .i_q_valid (qc_valid),
        .o_q_ready (qc_ready),
        .i_q_job   (qc_job),
        .o_ret     (ret),
        .o_blk     (o_blk)
    );
endmodule
